// ===== hw/rtl/rmis_pkg.sv =====
package rmis_pkg;

	localparam int REGISTER_COUNT = 6;
	localparam int DATA_WIDTH     = 32;
	localparam int REG_IDX_W      = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	localparam int INDEX_W    = 32;
	localparam int OPND_W     = 31;
	localparam int DEST_W     = 3;
	localparam int IPREG_W    = 3;
	localparam int PLEN_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// compare width that holds a signed register and a non-negative immediate
	localparam int CMP_W = ((DATA_WIDTH > OPND_W) ? DATA_WIDTH : OPND_W) + 1;

	typedef enum logic [3:0] {
		OP_ADDR, OP_ADDI, OP_MULR, OP_MULI,
		OP_BANR, OP_BANI, OP_BORR, OP_BORI,
		OP_SETR, OP_SETI, OP_GTIR, OP_GTRI,
		OP_GTRR, OP_EQIR, OP_EQRI, OP_EQRR
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IP_REGISTER    = 4'd0,
		CFG_PROGRAM_LENGTH = 4'd1
	} cfg_reg_t;

	// index bound into a register: sign-extended or truncated to the data width
	function automatic logic [DATA_WIDTH-1:0] idx_to_data(input logic [INDEX_W-1:0] i);
		return DATA_WIDTH'($signed(i));
	endfunction

	// register value back to a 32-bit index, sign-extended from the data width
	function automatic logic [INDEX_W-1:0] data_to_idx(input logic [DATA_WIDTH-1:0] v);
		return INDEX_W'($signed(v));
	endfunction

	function automatic logic index_valid(input logic [INDEX_W-1:0] i,
		input logic [PLEN_W-1:0] len);
		return !i[INDEX_W-1] && (i < INDEX_W'(len));
	endfunction

	function automatic logic reg_ok(input logic [INDEX_W-1:0] r);
		return r < INDEX_W'(REGISTER_COUNT);
	endfunction

endpackage

// ===== hw/rtl/rmis_ifs.sv =====
interface rmis_instr_if;
	logic                           valid;
	logic                           ready;
	logic [3:0]                     func;
	logic [rmis_pkg::OPND_W-1:0]    operand_a;
	logic [rmis_pkg::OPND_W-1:0]    operand_b;
	logic [rmis_pkg::DEST_W-1:0]    dest_reg;

	modport source (output valid, func, operand_a, operand_b, dest_reg, input ready);
	modport sink   (input valid, func, operand_a, operand_b, dest_reg, output ready);
endinterface

interface rmis_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rmis_pkg::INDEX_W-1:0]  next_index;
	logic signed [rmis_pkg::INDEX_W-1:0]  first_register;
	logic                                 halted;
	logic                                 bad_operand;

	modport source (output valid, next_index, first_register, halted, bad_operand,
		input ready);
	modport sink   (input valid, next_index, first_register, halted, bad_operand,
		output ready);
endinterface

interface rmis_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rmis_pkg::CFG_IDX_W-1:0]    index;
	logic [rmis_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rmis_alu.sv =====
module rmis_alu (
	input  rmis_pkg::op_t                    op,
	input  logic [rmis_pkg::DATA_WIDTH-1:0]  ra,
	input  logic [rmis_pkg::DATA_WIDTH-1:0]  rb,
	input  logic [rmis_pkg::OPND_W-1:0]      a,
	input  logic [rmis_pkg::OPND_W-1:0]      b,
	output logic [rmis_pkg::DATA_WIDTH-1:0]  r
);
	localparam int DW = rmis_pkg::DATA_WIDTH;
	localparam int CW = rmis_pkg::CMP_W;

	logic [DW-1:0] a_d;
	logic [DW-1:0] b_d;
	logic [DW-1:0] mul_b;
	logic [DW-1:0] prod;
	logic          flag;

	assign a_d   = DW'(a);
	assign b_d   = DW'(b);
	assign mul_b = (op == rmis_pkg::OP_MULR) ? rb : b_d;
	assign prod  = ra * mul_b;

	always_comb begin
		flag = 1'b0;
		case (op)
			rmis_pkg::OP_GTIR: flag = $signed(a_d) > $signed(rb);
			rmis_pkg::OP_GTRI: flag = $signed(CW'($signed(ra))) > $signed(CW'(b));
			rmis_pkg::OP_GTRR: flag = $signed(ra) > $signed(rb);
			rmis_pkg::OP_EQIR: flag = CW'(a) == CW'($signed(rb));
			rmis_pkg::OP_EQRI: flag = CW'($signed(ra)) == CW'(b);
			rmis_pkg::OP_EQRR: flag = ra == rb;
			default:           flag = 1'b0;
		endcase
	end

	always_comb begin
		case (op)
			rmis_pkg::OP_ADDR: r = ra + rb;
			rmis_pkg::OP_ADDI: r = ra + b_d;
			rmis_pkg::OP_MULR,
			rmis_pkg::OP_MULI: r = prod;
			rmis_pkg::OP_BANR: r = ra & rb;
			rmis_pkg::OP_BANI: r = ra & b_d;
			rmis_pkg::OP_BORR: r = ra | rb;
			rmis_pkg::OP_BORI: r = ra | b_d;
			rmis_pkg::OP_SETR: r = ra;
			rmis_pkg::OP_SETI: r = a_d;
			default:           r = {{(DW-1){1'b0}}, flag};
		endcase
	end

endmodule

// ===== hw/rtl/register_machine_instruction_step.sv =====
// Register machine, one instruction per item.
// instr: an instruction (func, operand_a, operand_b, dest_reg) fetched at the
//   index last reported; accepted when valid and ready are high at a clock edge.
// result: next_index, first_register, halted, bad_operand, one item per
//   instruction, in order.
// cfg: register writes (index 0 ip_register, index 1 program_length), always
//   ready; write only while no instruction is in flight.
// Order: the instruction passes the input register and then the result register,
//   which loads only while result is not stalled. Throughput: one instruction
//   per cycle while result is not stalled and no ip_register write is pending;
//   the forwarded register read, the multiplier and the index compare set the clock.
// Register file: six-entry memory with two registered read ports, per-entry
//   valid bits and forwarding of the last write; the register bound to the
//   index is held aside and written back after ip_register is changed, once
//   the input register is empty; until then instr.ready is low.
// Reset (arst_n low): registers, index and halt flag clear, program_length is
//   zero, so the first instruction reports halted until it is configured.
// When result is stalled the finished item is held, one more instruction may
//   wait in the input register, and instr.ready then drops.
module register_machine_instruction_step (
	input  logic         clk,
	input  logic         arst_n,
	rmis_instr_if.sink   instr,
	rmis_result_if.source result,
	rmis_cfg_if.sink     cfg
);
	localparam int DW  = rmis_pkg::DATA_WIDTH;
	localparam int RC  = rmis_pkg::REGISTER_COUNT;
	localparam int RIW = rmis_pkg::REG_IDX_W;
	localparam int IW  = rmis_pkg::INDEX_W;
	localparam int OW  = rmis_pkg::OPND_W;
	localparam int PW  = rmis_pkg::PLEN_W;
	localparam int IPW = rmis_pkg::IPREG_W;
	localparam int DSW = rmis_pkg::DEST_W;

	// configuration
	logic [IPW-1:0] ip_reg_q;
	logic [PW-1:0]  prog_len_q;
	logic           flush_pend_q;

	// architectural state
	logic [IW-1:0]  idx_q;
	logic           halt_q;
	logic [DW-1:0]  reg0_q;
	logic [DW-1:0]  ipval_q;
	logic [RIW-1:0] tag_q;
	logic           dirty_q;

	// register file memory
	logic [DW-1:0]  mem [RC];
	logic [RC-1:0]  mem_vld_q;
	logic           rec_vld_q;
	logic [RIW-1:0] rec_addr_q;
	logic [DW-1:0]  rec_data_q;
	logic           mem_we;
	logic [RIW-1:0] mem_wa;
	logic [DW-1:0]  mem_wd;

	// input stage
	logic           s1_valid_q;
	rmis_pkg::op_t  op_s1;
	logic [OW-1:0]  a_s1;
	logic [OW-1:0]  b_s1;
	logic [DSW-1:0] d_s1;
	logic [DW-1:0]  rda_s1;
	logic [DW-1:0]  rdb_s1;

	// result register
	logic           out_valid_q;
	logic [IW-1:0]  out_next_q;
	logic [IW-1:0]  out_reg0_q;
	logic           out_halt_q;
	logic           out_bad_q;

	logic accept;
	logic retire;
	logic flush_go;

	logic           run;
	logic           ip_ok;
	logic [RIW-1:0] ip_addr;
	logic [RIW-1:0] a_addr;
	logic [RIW-1:0] b_addr;
	logic [RIW-1:0] d_addr;
	logic [DW-1:0]  bound;
	logic           a_reg;
	logic           b_reg;
	logic           opnd_bad;
	logic [DW-1:0]  ra_v;
	logic [DW-1:0]  rb_v;
	logic [DW-1:0]  alu_r;
	logic           wr_op;
	logic [DW-1:0]  ip_after;
	logic [IW-1:0]  nxt;
	logic           halted;
	logic           bad;
	logic [DW-1:0]  reg0_new;

	assign cfg.ready    = 1'b1;
	assign flush_go     = flush_pend_q && !s1_valid_q;
	assign retire       = s1_valid_q && (!out_valid_q || result.ready);
	assign instr.ready  = !flush_pend_q && (!s1_valid_q || retire);
	assign accept       = instr.valid && instr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_reg_q     <= '0;
			prog_len_q   <= '0;
			flush_pend_q <= 1'b0;
		end else begin
			if (flush_go)
				flush_pend_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg.index)
					rmis_pkg::CFG_IP_REGISTER: begin
						ip_reg_q     <= cfg.data[IPW-1:0];
						flush_pend_q <= 1'b1;
					end
					rmis_pkg::CFG_PROGRAM_LENGTH: prog_len_q <= cfg.data[PW-1:0];
					default: ;
				endcase
			end
		end
	end

	// execute
	always_comb begin
		run     = !halt_q && rmis_pkg::index_valid(idx_q, prog_len_q);
		ip_ok   = rmis_pkg::reg_ok(IW'(ip_reg_q));
		ip_addr = RIW'(ip_reg_q);
		a_addr  = RIW'(a_s1);
		b_addr  = RIW'(b_s1);
		d_addr  = RIW'(d_s1);
		bound   = rmis_pkg::idx_to_data(idx_q);
		a_reg   = !(op_s1 inside {rmis_pkg::OP_SETI, rmis_pkg::OP_GTIR, rmis_pkg::OP_EQIR});
		b_reg   = op_s1 inside {rmis_pkg::OP_ADDR, rmis_pkg::OP_MULR, rmis_pkg::OP_BANR,
			rmis_pkg::OP_BORR, rmis_pkg::OP_GTIR, rmis_pkg::OP_GTRR,
			rmis_pkg::OP_EQIR, rmis_pkg::OP_EQRR};
		opnd_bad = (a_reg && !rmis_pkg::reg_ok(IW'(a_s1)))
			|| (b_reg && !rmis_pkg::reg_ok(IW'(b_s1)))
			|| !rmis_pkg::reg_ok(IW'(d_s1));

		// bound register, then last write, then memory, then reset value
		if (a_addr == ip_addr)
			ra_v = bound;
		else if (rec_vld_q && rec_addr_q == a_addr)
			ra_v = rec_data_q;
		else if (mem_vld_q[a_addr])
			ra_v = rda_s1;
		else
			ra_v = '0;

		if (b_addr == ip_addr)
			rb_v = bound;
		else if (rec_vld_q && rec_addr_q == b_addr)
			rb_v = rec_data_q;
		else if (mem_vld_q[b_addr])
			rb_v = rdb_s1;
		else
			rb_v = '0;
	end

	rmis_alu u_alu (
		.op (op_s1),
		.ra (ra_v),
		.rb (rb_v),
		.a  (a_s1),
		.b  (b_s1),
		.r  (alu_r)
	);

	always_comb begin
		wr_op    = run && ip_ok && !opnd_bad;
		ip_after = (wr_op && d_addr == ip_addr) ? alu_r : bound;
		nxt      = idx_q;
		halted   = 1'b1;
		bad      = 1'b0;
		reg0_new = reg0_q;
		if (run) begin
			if (!ip_ok) begin
				nxt = idx_q + IW'(1);
				bad = 1'b1;
			end else begin
				nxt = rmis_pkg::data_to_idx(ip_after + DW'(1));
				bad = opnd_bad;
				if (wr_op && d_addr == '0)
					reg0_new = alu_r;
				else if (ip_addr == '0)
					reg0_new = bound;
			end
			halted = !rmis_pkg::index_valid(nxt, prog_len_q);
		end
	end

	// one write port: a step write or the write-back of the bound register
	always_comb begin
		mem_we = 1'b0;
		mem_wa = d_addr;
		mem_wd = alu_r;
		if (retire && wr_op && d_addr != ip_addr) begin
			mem_we = 1'b1;
		end else if (flush_go && dirty_q) begin
			mem_we = 1'b1;
			mem_wa = tag_q;
			mem_wd = ipval_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (accept) begin
			rda_s1 <= mem[RIW'(instr.operand_a)];
			rdb_s1 <= mem[RIW'(instr.operand_b)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
			rec_vld_q <= 1'b0;
		end else if (mem_we) begin
			mem_vld_q[mem_wa] <= 1'b1;
			rec_vld_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rec_addr_q <= mem_wa;
			rec_data_q <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			halt_q  <= 1'b0;
			reg0_q  <= '0;
			ipval_q <= '0;
			tag_q   <= '0;
			dirty_q <= 1'b0;
		end else begin
			if (retire) begin
				idx_q  <= nxt;
				halt_q <= halted;
				reg0_q <= reg0_new;
				if (run && ip_ok) begin
					ipval_q <= ip_after;
					dirty_q <= 1'b1;
				end
			end else if (flush_go) begin
				tag_q   <= ip_addr;
				dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (retire)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= rmis_pkg::op_t'(instr.func);
			a_s1  <= instr.operand_a;
			b_s1  <= instr.operand_b;
			d_s1  <= instr.dest_reg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (retire)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			out_next_q <= nxt;
			out_reg0_q <= IW'(reg0_new);
			out_halt_q <= halted;
			out_bad_q  <= bad;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.next_index     = out_next_q;
	assign result.first_register = out_reg0_q;
	assign result.halted         = out_halt_q;
	assign result.bad_operand    = out_bad_q;

endmodule

// ===== dv/rmis_step_checker.sv =====
module rmis_step_checker
	import rmis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	rmis_instr_if              instr,
	rmis_result_if             result,
	rmis_cfg_if                cfg,
	output int                 fail_count,
	output int                 reports_due,
	output logic [INDEX_W-1:0] cur_index
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [INDEX_W-1:0] next_index;
		logic [INDEX_W-1:0] first_register;
		logic               halted;
		logic               bad_operand;
	} step_report_t;

	logic [DATA_WIDTH-1:0] regs [REGISTER_COUNT];
	logic [INDEX_W-1:0]    pc;
	logic                  halt_seen;
	logic [IPREG_W-1:0]    ip_sel;
	logic [PLEN_W-1:0]     plen;
	step_report_t          report_q [$];
	int                    shown;

	function automatic logic in_range(input logic [INDEX_W-1:0] i);
		return (i[INDEX_W-1] == 1'b0) && (i[INDEX_W-2:0] < (INDEX_W-1)'(plen));
	endfunction

	function automatic step_report_t run_instruction(input op_t f,
		input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
		input logic [DEST_W-1:0] d);
		step_report_t                rep;
		logic                        a_reg;
		logic                        b_reg;
		logic                        bad;
		logic [DATA_WIDTH-1:0]       ra;
		logic [DATA_WIDTH-1:0]       vb;
		logic [DATA_WIDTH-1:0]       val;
		logic signed [DATA_WIDTH:0]  sra;
		logic signed [DATA_WIDTH:0]  svb;
		logic signed [DATA_WIDTH:0]  ia;
		logic [INDEX_W-1:0]          nxt;
		if (halt_seen || !in_range(pc)) begin
			halt_seen = 1'b1;
			rep = '{pc, regs[0], 1'b1, 1'b0};
			return rep;
		end
		bad = 1'b0;
		if (ip_sel >= REGISTER_COUNT) begin
			bad = 1'b1;
			nxt = pc + 1'b1;
		end else begin
			regs[ip_sel] = pc;
			a_reg = !(f inside {OP_SETI, OP_GTIR, OP_EQIR});
			b_reg = f inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
				OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR};
			if ((a_reg && a >= REGISTER_COUNT) || (b_reg && b >= REGISTER_COUNT) ||
				d >= REGISTER_COUNT) begin
				bad = 1'b1;
			end else begin
				ra  = a_reg ? regs[a] : '0;
				vb  = b_reg ? regs[b] : DATA_WIDTH'(b);
				sra = {ra[DATA_WIDTH-1], ra};
				svb = b_reg ? {vb[DATA_WIDTH-1], vb} : {1'b0, vb};
				ia  = {1'b0, DATA_WIDTH'(a)};
				case (f)
					OP_ADDR, OP_ADDI: val = ra + vb;
					OP_MULR, OP_MULI: val = ra * vb;
					OP_BANR, OP_BANI: val = ra & vb;
					OP_BORR, OP_BORI: val = ra | vb;
					OP_SETR:          val = ra;
					OP_SETI:          val = DATA_WIDTH'(a);
					OP_GTIR:          val = DATA_WIDTH'(ia > svb);
					OP_GTRI, OP_GTRR: val = DATA_WIDTH'(sra > svb);
					OP_EQIR:          val = DATA_WIDTH'(ia == svb);
					default:          val = DATA_WIDTH'(sra == svb);
				endcase
				regs[d] = val;
			end
			nxt = regs[ip_sel] + 1'b1;
		end
		pc = nxt;
		if (!in_range(nxt))
			halt_seen = 1'b1;
		rep = '{nxt, regs[0], halt_seen, bad};
		return rep;
	endfunction

	task automatic check_report();
		step_report_t want;
		step_report_t got;
		got = '{result.next_index, result.first_register, result.halted, result.bad_operand};
		if (report_q.size() == 0) begin
			fail_count++;
			if (shown < 10)
				$display("unexpected result item: next_index %h first_register %h halted %b bad %b",
					got.next_index, got.first_register, got.halted, got.bad_operand);
			shown++;
			return;
		end
		want = report_q.pop_front();
		if (got.next_index !== want.next_index || got.first_register !== want.first_register ||
			got.halted !== want.halted || got.bad_operand !== want.bad_operand) begin
			fail_count++;
			if (shown < 10)
				$display("wrong result item: want %h %h %b %b got %h %h %b %b",
					want.next_index, want.first_register, want.halted, want.bad_operand,
					got.next_index, got.first_register, got.halted, got.bad_operand);
			shown++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regs[i])
				regs[i] = '0;
			pc = '0;
			halt_seen = 1'b0;
			ip_sel = '0;
			plen = '0;
			report_q.delete();
			fail_count = 0;
			shown = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_IP_REGISTER:    ip_sel = cfg.data[IPREG_W-1:0];
					CFG_PROGRAM_LENGTH: plen = cfg.data[PLEN_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready)
				check_report();
			if (instr.valid && instr.ready)
				report_q.push_back(run_instruction(op_t'(instr.func), instr.operand_a,
					instr.operand_b, instr.dest_reg));
		end
		reports_due = report_q.size();
		cur_index = pc;
	end

endmodule

// ===== dv/tb_register_machine_instruction_step.sv =====
module tb_register_machine_instruction_step;
	timeunit 1ns;
	timeprecision 1ps;

	import rmis_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	logic               clk;
	logic               arst_n;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	bit                 hold_now;
	logic [IPREG_W-1:0] ip_now;
	int                 len_now;
	int                 fail_count;
	int                 reports_due;
	logic [INDEX_W-1:0] cur_index;

	rmis_instr_if  instr_ch ();
	rmis_result_if result_ch ();
	rmis_cfg_if    cfg_ch ();

	register_machine_instruction_step u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	rmis_step_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.reports_due (reports_due),
		.cur_index   (cur_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [OPND_W-1:0] pick_reg();
		if ($urandom_range(0, 99) < 92)
			return OPND_W'($urandom_range(0, 5));
		if ($urandom_range(0, 1))
			return OPND_W'($urandom_range(6, 7));
		return OPND_W'($urandom);
	endfunction

	function automatic logic [OPND_W-1:0] pick_imm();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return OPND_W'($urandom_range(0, 15));
			9:             return $urandom_range(0, 1) ? '1 : '0;
			default:       return OPND_W'($urandom);
		endcase
	endfunction

	task automatic send_instr(input op_t f, input logic [OPND_W-1:0] a,
		input logic [OPND_W-1:0] b, input logic [DEST_W-1:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			instr_ch.valid <= 1'b0;
			@(negedge clk);
		end
		instr_ch.valid     <= 1'b1;
		instr_ch.func      <= f;
		instr_ch.operand_a <= a;
		instr_ch.operand_b <= b;
		instr_ch.dest_reg  <= d;
		do @(posedge clk); while (!instr_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		instr_ch.valid <= 1'b0;
		@(negedge clk);
		while (reports_due != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// jump back to index 1 through the bound register
	task automatic rewind_index();
		if (len_now != 0 && ip_now < REGISTER_COUNT)
			send_instr(OP_SETI, '0, pick_imm(), DEST_W'(ip_now));
	endtask

	task automatic set_config(input int ip, input int len);
		rewind_index();
		write_reg(CFG_IP_REGISTER, CFG_DATA_W'(ip));
		ip_now = IPREG_W'(ip);
		rewind_index();
		write_reg(CFG_PROGRAM_LENGTH, CFG_DATA_W'(len));
		len_now = len;
	endtask

	// while the bound register exists, keeps the index inside the program so the machine does not halt early
	task automatic send_random();
		op_t                 f;
		logic [OPND_W-1:0]   a;
		logic [OPND_W-1:0]   b;
		logic [DEST_W-1:0]   d;
		f = op_t'($urandom_range(0, 15));
		a = (f inside {OP_SETI, OP_GTIR, OP_EQIR}) ? pick_imm() : pick_reg();
		b = (f inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR,
			OP_EQRR}) ? pick_reg() : pick_imm();
		d = ($urandom_range(0, 99) < 4) ? DEST_W'($urandom_range(6, 7))
			: DEST_W'($urandom_range(0, 5));
		if (ip_now < REGISTER_COUNT) begin
			if (cur_index + 32'd3 >= 32'(len_now)) begin
				f = OP_SETI;
				a = OPND_W'($urandom_range(0, 2));
				d = DEST_W'(ip_now);
			end else if (d == ip_now && !(f inside {[OP_GTIR:OP_EQRR]})) begin
				if ($urandom_range(0, 1)) begin
					f = OP_SETI;
					a = OPND_W'($urandom_range(0, len_now - 3));
				end else begin
					d = DEST_W'((ip_now + $urandom_range(1, 5)) % REGISTER_COUNT);
				end
			end
		end
		send_instr(f, a, b, d);
	endtask

	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_now) begin
				hold_now = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("register_machine_instruction_step: mismatch");
		$finish;
	end

	initial begin
		instr_ch.valid     = 1'b0;
		instr_ch.func      = '0;
		instr_ch.operand_a = '0;
		instr_ch.operand_b = '0;
		instr_ch.dest_reg  = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		send_idle_pct      = 28;
		recv_idle_pct      = 76;
		hold_now           = 1'b0;
		ip_now             = '0;
		len_now            = 0;
		arst_n             = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_config(0, 65535);
		send_instr(OP_SETI, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 3'd1);
		send_instr(OP_ADDI, 31'd1, 31'h7FFF_FFFF, 3'd2);
		send_instr(OP_ADDR, 31'd2, 31'd2, 3'd3);
		send_instr(OP_MULR, 31'd2, 31'd1, 3'd4);
		send_instr(OP_MULI, 31'd1, 31'h7FFF_FFFF, 3'd5);
		send_instr(OP_BANR, 31'd2, 31'd5, 3'd3);
		send_instr(OP_BANI, 31'd2, 31'h5555_5555, 3'd4);
		send_instr(OP_BORR, 31'd3, 31'd4, 3'd5);
		send_instr(OP_BORI, 31'd0, 31'h2AAA_AAAA, 3'd1);
		send_instr(OP_SETR, 31'd2, 31'h7FFF_FFFF, 3'd3);
		send_instr(OP_GTIR, 31'h7FFF_FFFF, 31'd2, 3'd4);
		send_instr(OP_GTRI, 31'd2, 31'd0, 3'd5);
		send_instr(OP_GTRR, 31'd1, 31'd2, 3'd4);
		send_instr(OP_EQIR, 31'd0, 31'd0, 3'd5);
		send_instr(OP_EQRI, 31'd1, 31'h7FFF_FFFF, 3'd4);
		send_instr(OP_EQRR, 31'd3, 31'd3, 3'd5);
		// bad register operands and destinations
		send_instr(OP_ADDR, 31'd6, 31'd0, 3'd1);
		send_instr(OP_ADDI, 31'h7FFF_FFFF, 31'd4, 3'd1);
		send_instr(OP_MULR, 31'd1, 31'h4000_0000, 3'd2);
		send_instr(OP_SETI, 31'd5, 31'd0, 3'd7);
		send_instr(OP_GTRR, 31'd1, 31'd2, 3'd6);
		// writes to the bound register
		send_instr(OP_SETI, 31'd9, 31'd0, 3'd0);
		send_instr(OP_EQRR, 31'd0, 31'd0, 3'd0);
		send_instr(OP_GTIR, 31'h7FFF_FFFF, 31'd0, 3'd0);

		set_config(5, 65535);
		hold_now = 1'b1;
		repeat (160) send_random();
		set_config(6, 65535);
		repeat (20) send_random();
		set_config(7, 65535);
		repeat (20) send_random();

		send_idle_pct = 76;
		recv_idle_pct = 28;
		set_config(3, 12);
		repeat (50) send_random();
		wait_drained();
		repeat (50) send_random();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(0, 500);
		repeat (150) send_random();

		// negative next index halts for good
		send_instr(OP_SETI, 31'h7FFF_FFFF, pick_imm(), DEST_W'(ip_now));
		repeat (3) send_random();
		write_reg(CFG_PROGRAM_LENGTH, '0);
		repeat (3) send_random();

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && reports_due == 0)
			$display("register_machine_instruction_step: match");
		else
			$display("register_machine_instruction_step: mismatch");
		$finish;
	end

endmodule
